### sv/dks_pkg.sv
// ----------------------------------------------------------------------------
// dks_pkg: shared types for the date key record sorter
// Record layout kept in the cell memory and the widths of its fields.
// ----------------------------------------------------------------------------
package dks_pkg;

  localparam int unsigned NUM_W   = 7;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned KEY_W   = YEAR_W + MONTH_W + DAY_W;

  // one stored record: arrival number followed by the composite date key
  typedef struct packed {
    logic [NUM_W-1:0]   num;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } rec_t;

  localparam int unsigned REC_W = $bits(rec_t);

  // date key used for ordering: year, then month, then day
  function automatic logic [KEY_W-1:0] rec_key(input rec_t r);
    return {r.year, r.month, r.day};
  endfunction

endpackage

### sv/date_key_record_sorter.sv
// Insertion: an empty set takes the word straight into the first cell and a full
//   set drops it; else stored records with later dates move up one cell (one memory read a cycle).
// Output: each sorted word passes the memory read, then the output register,
//   and is held while the receiver stalls; the set empties after the last word.
// Synchronous active-low reset clears the record count and the sequencer;
//   the cell memory is not cleared, only cells below the count are read.
// ----------------------------------------------------------------------------
// date_key_record_sorter: stable insertion sort of records by date
// Keeps records sorted in a cell memory and emits them on the last word.
// ----------------------------------------------------------------------------
module date_key_record_sorter
  import dks_pkg::*;
#(
  parameter int unsigned MAX_RECORDS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [YEAR_W-1:0]  in_birth_year,
  input  logic [MONTH_W-1:0] in_birth_month,
  input  logic [DAY_W-1:0]   in_birth_day,
  input  logic               in_last_item,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [NUM_W-1:0]   out_arrival_number,
  output logic [YEAR_W-1:0]  out_year,
  output logic [MONTH_W-1:0] out_month,
  output logic [DAY_W-1:0]   out_day,
  output logic               out_end_of_list
);

  localparam int unsigned AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int unsigned CW = $clog2(MAX_RECORDS + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_PLACE,
    ST_WAIT,
    ST_OUT
  } state_t;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CW-1:0]   pos_r, pos_nxt;
  logic [CW-1:0]   idx_r, idx_nxt;
  rec_t            new_r, new_nxt;
  logic            last_r, last_nxt;
  rec_t            out_rec_r, out_rec_nxt;
  logic            out_eol_r, out_eol_nxt;
  logic            out_valid_r, out_valid_nxt;

  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  rec_t            wr_data;
  logic [AW-1:0]   rd_addr;
  rec_t            rd_data;

  logic [CW:0]     cnt_inc;
  logic [CW-1:0]   count_m1;
  logic [CW-1:0]   pos_m1;
  logic [CW-1:0]   pos_m2;
  logic [CW-1:0]   idx_p1;
  rec_t            in_rec;

  assign cnt_inc  = {1'b0, count_r} + 1'b1;
  assign count_m1 = count_r - 1'b1;
  assign pos_m1   = pos_r - 1'b1;
  assign pos_m2   = pos_r - CW'(2);
  assign idx_p1   = idx_r + 1'b1;

  // pack the incoming word with its arrival number
  always_comb begin
    in_rec.num   = NUM_W'(cnt_inc);
    in_rec.year  = in_birth_year;
    in_rec.month = in_birth_month;
    in_rec.day   = in_birth_day;
  end

  dks_cell_mem #(
    .DEPTH (MAX_RECORDS),
    .AW    (AW)
  ) u_cell_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // sequence insertion shifts and the sorted readout
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    idx_nxt       = idx_r;
    new_nxt       = new_r;
    last_nxt      = last_r;
    out_rec_nxt   = out_rec_r;
    out_eol_nxt   = out_eol_r;
    out_valid_nxt = out_valid_r;
    wr_en         = 1'b0;
    wr_addr       = pos_r[AW-1:0];
    wr_data       = new_r;
    rd_addr       = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          new_nxt  = in_rec;
          last_nxt = in_last_item;
          idx_nxt  = '0;
          if (count_r == '0) begin
            // empty set: place directly in the first cell
            wr_en     = 1'b1;
            wr_addr   = '0;
            wr_data   = in_rec;
            count_nxt = CW'(1);
            if (in_last_item) begin
              state_nxt = ST_WAIT;
            end
          end else if (count_r < CW'(MAX_RECORDS)) begin
            // start the walk down from the top cell
            pos_nxt   = count_r;
            rd_addr   = count_m1[AW-1:0];
            state_nxt = ST_SHIFT;
          end else if (in_last_item) begin
            // full set: drop the word but still emit
            state_nxt = ST_WAIT;
          end
        end
      end

      ST_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = pos_r[AW-1:0];
        if (rec_key(rd_data) > rec_key(new_r)) begin
          // move the later record up one cell
          wr_data = rd_data;
          pos_nxt = pos_m1;
          if (pos_r == CW'(1)) begin
            state_nxt = ST_PLACE;
          end else begin
            rd_addr = pos_m2[AW-1:0];
          end
        end else begin
          wr_data   = new_r;
          count_nxt = cnt_inc[CW-1:0];
          state_nxt = last_r ? ST_WAIT : ST_IDLE;
        end
      end

      ST_PLACE: begin
        wr_en     = 1'b1;
        wr_addr   = '0;
        wr_data   = new_r;
        count_nxt = cnt_inc[CW-1:0];
        state_nxt = last_r ? ST_WAIT : ST_IDLE;
      end

      ST_WAIT: begin
        // capture the cell read at idx
        out_rec_nxt   = rd_data;
        out_eol_nxt   = (idx_p1 == count_r);
        out_valid_nxt = 1'b1;
        state_nxt     = ST_OUT;
      end

      ST_OUT: begin
        rd_addr = idx_p1[AW-1:0];
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          if (out_eol_r) begin
            count_nxt = '0;
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt   = idx_p1;
            state_nxt = ST_WAIT;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (state_r == ST_IDLE || state_r == ST_SHIFT || state_r == ST_PLACE) begin
      if (state_nxt == ST_WAIT) begin
        rd_addr = '0;
      end
    end
  end

  // hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      last_r      <= 1'b0;
      idx_r       <= '0;
      pos_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      last_r      <= last_nxt;
      idx_r       <= idx_nxt;
      pos_r       <= pos_nxt;
    end
    new_r     <= new_nxt;
    out_rec_r <= out_rec_nxt;
    out_eol_r <= out_eol_nxt;
  end

  assign in_stall           = (state_r != ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_arrival_number = out_rec_r.num;
  assign out_year           = out_rec_r.year;
  assign out_month          = out_rec_r.month;
  assign out_day            = out_rec_r.day;
  assign out_end_of_list    = out_eol_r;

`ifndef NO_ASSERTIONS
  // count never exceeds the memory depth
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_RECORDS))
    else $error("record count above depth");

  // no input word is taken while results are pending
  a_no_accept_on_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open during readout");

  // the set is empty after the final word leaves
  a_empty_after_eol: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_end_of_list) |=> (count_r == '0))
    else $error("set not emptied after last word");

  // output words only come from a nonempty set
  a_out_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (count_r != '0))
    else $error("output word from empty set");
`endif

endmodule

### sv/dks_cell_mem.sv
// ----------------------------------------------------------------------------
// dks_cell_mem: record cell memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module dks_cell_mem
  import dks_pkg::*;
#(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  rec_t          wr_data,
  input  logic [AW-1:0] rd_addr,
  output rec_t          rd_data
);

  rec_t mem [DEPTH];

  // write the cell
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // register the read word; forward a write to the same cell in this cycle
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data <= wr_data;
    end else begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: date key record sorter
// Feeds sets of dated records (full sets with drops, equal dates, raw
// out-of-range fields) and checks each sorted output word against a stable
// insertion-sort prediction held in a small scoreboard.
// ----------------------------------------------------------------------------
module testbench;
  import dks_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CHAIN_DEPTH = 64;

  // expected output word
  typedef struct {
    logic [NUM_W-1:0]   num;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic               eol;
  } sorted_word_t;

  // scoreboard: keeps the sorted chain and the words still owed
  class sort_scoreboard;
    rec_t         chain[$];
    sorted_word_t owed[$];
    int           errors;

    function void note_record(logic [YEAR_W-1:0] y, logic [MONTH_W-1:0] m,
                              logic [DAY_W-1:0] d, logic last);
      rec_t r;
      int   pos;
      sorted_word_t w;
      // insert behind every equal or earlier date; drop when full
      if (chain.size() < CHAIN_DEPTH) begin
        r.num = NUM_W'(chain.size() + 1);
        r.year = y;
        r.month = m;
        r.day = d;
        pos = chain.size();
        while (pos > 0 && {chain[pos-1].year, chain[pos-1].month, chain[pos-1].day}
                          > {y, m, d})
          pos--;
        chain.insert(pos, r);
      end
      if (last) begin
        foreach (chain[i]) begin
          w.num = chain[i].num;
          w.year = chain[i].year;
          w.month = chain[i].month;
          w.day = chain[i].day;
          w.eol = (i == chain.size() - 1);
          owed.insert(owed.size(), w);
        end
        chain.delete();
      end
    endfunction

    function void check_word(logic [NUM_W-1:0] n, logic [YEAR_W-1:0] y,
                             logic [MONTH_W-1:0] m, logic [DAY_W-1:0] d, logic e);
      sorted_word_t w;
      if (owed.size() == 0) begin
        $error("unexpected output word num=%0d", n);
        errors++;
        return;
      end
      w = owed.pop_front();
      if (n !== w.num) begin
        $error("arrival_number: expected %0d, got %0d", w.num, n); errors++;
      end
      if (y !== w.year) begin
        $error("out_year: expected %0d, got %0d", w.year, y); errors++;
      end
      if (m !== w.month) begin
        $error("out_month: expected %0d, got %0d", w.month, m); errors++;
      end
      if (d !== w.day) begin
        $error("out_day: expected %0d, got %0d", w.day, d); errors++;
      end
      if (e !== w.eol) begin
        $error("end_of_list: expected %0d, got %0d", w.eol, e); errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [YEAR_W-1:0]  in_birth_year = '0;
  logic [MONTH_W-1:0] in_birth_month = '0;
  logic [DAY_W-1:0]   in_birth_day = '0;
  logic               in_last_item = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b1;
  logic [NUM_W-1:0]   out_arrival_number;
  logic [YEAR_W-1:0]  out_year;
  logic [MONTH_W-1:0] out_month;
  logic [DAY_W-1:0]   out_day;
  logic               out_end_of_list;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_off_cycles = 0;
  sort_scoreboard board = new();

  date_key_record_sorter dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver: check each accepted word; random stall, or a long hold-off when asked
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_word(out_arrival_number, out_year, out_month, out_day,
                       out_end_of_list);
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // offer one word, with random idle cycles ahead of it
  task automatic send_record(logic [YEAR_W-1:0] y, logic [MONTH_W-1:0] m,
                             logic [DAY_W-1:0] d, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_birth_year <= y;
    in_birth_month <= m;
    in_birth_day <= d;
    in_last_item <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_record(y, m, d, last);
  endtask

  task automatic send_random_set(int count);
    for (int i = 0; i < count; i++) begin
      // mostly legal dates, sometimes raw field values; small year range for ties
      if ($urandom_range(9) == 0)
        send_record(YEAR_W'($urandom), MONTH_W'($urandom), DAY_W'($urandom),
                    i == count - 1);
      else
        send_record(YEAR_W'($urandom_range(1990, 1995)),
                    MONTH_W'($urandom_range(1, 12)),
                    DAY_W'($urandom_range(1, 31)), i == count - 1);
    end
  endtask

  task automatic drain_sender();
    in_valid <= 1'b0;
  endtask

  initial begin
    int sent;
    int n;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, equal dates, single-record set
    send_record(14'd9999, 4'd12, 5'd31, 1'b0);
    send_record(14'd0, 4'd1, 5'd1, 1'b0);
    send_record(14'd2000, 4'd6, 5'd15, 1'b0);
    send_record(14'd2000, 4'd6, 5'd15, 1'b0);
    send_record(14'd2000, 4'd6, 5'd14, 1'b0);
    send_record(14'd2000, 4'd5, 5'd31, 1'b0);
    send_record(14'h3FFF, 4'hF, 5'h1F, 1'b0);
    send_record(14'd0, 4'd0, 5'd0, 1'b1);
    send_record(14'd1234, 4'd7, 5'd7, 1'b1);
    send_record(14'd2000, 4'd6, 5'd15, 1'b0);
    send_record(14'd2000, 4'd6, 5'd15, 1'b1);

    // full chain with two dropped records, the second marked last
    send_idle_pct = 19; recv_idle_pct = 75;
    for (int i = 0; i < CHAIN_DEPTH + 2; i++)
      send_record(YEAR_W'($urandom), MONTH_W'($urandom), DAY_W'($urandom),
                  i == CHAIN_DEPTH + 1);

    // random sets across the idling phases; the last phase runs under a receiver hold-off
    sent = 0;
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 75 : 0;
      recv_idle_pct = (phase == 0) ? 75 : (phase == 1) ? 19 : 0;
      if (phase == 2) hold_off_cycles = 400;
      while (sent < 48 * (phase + 1)) begin
        n = $urandom_range(1, 12);
        send_random_set(n);
        sent += n;
      end
    end
    drain_sender();

    wait (board.owed.size() == 0);
    repeat (300) @(posedge clk);
    if (board.errors == 0 && board.owed.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  initial begin
    #4ms;
    $display("FAILURE");
    $finish;
  end

endmodule
